FILE: sv/ibac_pkg.sv
// Shared types, constants and helper functions for the IMU bias average and correct block.
package ibac_pkg;

    localparam int COUNT_BITS    = 24;
    localparam int SAMPLE_BITS   = 32;
    localparam int FRACTION_BITS = 16;
    localparam int CHANNELS      = 7;
    localparam int CHAN_BITS     = $clog2(CHANNELS);
    localparam int CFG_IDX_BITS  = 3;
    localparam int TOTAL_BITS    = COUNT_BITS + SAMPLE_BITS;
    localparam int ALU_BITS      = TOTAL_BITS + 2;
    localparam int STEP_BITS     = $clog2(TOTAL_BITS);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [TOTAL_BITS-1:0]  total_t;
    typedef logic signed [ALU_BITS-1:0]    alu_t;
    typedef logic [COUNT_BITS-1:0]         count_t;
    typedef logic [CHAN_BITS-1:0]          chan_t;

    localparam count_t  COUNT_MAX  = {COUNT_BITS{1'b1}};
    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Gravity (9.8) and unity (1.0) in the fixed-point sample format.
    localparam int GRAVITY_FIX = ((98 * (1 << FRACTION_BITS)) + 5) / 10;
    localparam int ONE_FIX     = 1 << FRACTION_BITS;

    localparam sample_t TARGET_RESET [CHANNELS] = '{
        sample_t'(0), sample_t'(0), sample_t'(GRAVITY_FIX),
        sample_t'(0), sample_t'(0), sample_t'(0), sample_t'(ONE_FIX)
    };

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic alu_t sext_sample(sample_t v);
        return {{(ALU_BITS-SAMPLE_BITS){v[SAMPLE_BITS-1]}}, v};
    endfunction

    function automatic alu_t sext_total(total_t v);
        return {{(ALU_BITS-TOTAL_BITS){v[TOTAL_BITS-1]}}, v};
    endfunction

endpackage

FILE: sv/ibac_alu.sv
// Shared add/subtract unit with saturation to the sample width.
module ibac_alu (
    input  ibac_pkg::alu_op_t op,
    input  ibac_pkg::alu_t    a,
    input  ibac_pkg::alu_t    b,
    output ibac_pkg::alu_t    sum,
    output ibac_pkg::sample_t sat
);

    logic in_range;

    always_comb
    begin
        if (op == ibac_pkg::ALU_SUB)
        begin
            sum = a - b;
        end
        else
        begin
            sum = a + b;
        end
    end

    // The result fits when every bit from the sample sign bit upward agrees.
    assign in_range = (&sum[ibac_pkg::ALU_BITS-1:ibac_pkg::SAMPLE_BITS-1])
                    | ~(|sum[ibac_pkg::ALU_BITS-1:ibac_pkg::SAMPLE_BITS-1]);

    always_comb
    begin
        if (in_range)
        begin
            sat = sum[ibac_pkg::SAMPLE_BITS-1:0];
        end
        else if (sum[ibac_pkg::ALU_BITS-1])
        begin
            sat = ibac_pkg::SAMPLE_MIN;
        end
        else
        begin
            sat = ibac_pkg::SAMPLE_MAX;
        end
    end

endmodule

FILE: sv/ibac_divider.sv
// Radix-2 restoring divider: signed total by unsigned count, truncated toward zero.
module ibac_divider (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  ibac_pkg::total_t    dividend,
    input  ibac_pkg::count_t    divisor,
    output ibac_pkg::total_t    quotient,
    output ibac_pkg::div_stat_t stat
);

    localparam int TB = ibac_pkg::TOTAL_BITS;
    localparam int CB = ibac_pkg::COUNT_BITS;

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic                           neg_reg, neg_next;
    logic [ibac_pkg::STEP_BITS-1:0] step_reg, step_next;
    logic [CB-1:0]                  rem_reg, rem_next;
    logic [CB-1:0]                  dvs_reg, dvs_next;
    logic [TB-1:0]                  quo_reg, quo_next;
    logic [CB:0]                    trial;
    logic                           fits;

    // Dividend bits shift out of the top of quo_reg while quotient bits enter below.
    assign trial = {rem_reg, quo_reg[TB-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            neg_next  = dividend[TB-1];
            step_next = '0;
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend[TB-1] ? -dividend : dividend;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? CB'(trial - {1'b0, dvs_reg}) : trial[CB-1:0];
            quo_next  = {quo_reg[TB-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == ibac_pkg::STEP_BITS'(TB - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            neg_reg  <= 1'b0;
            step_reg <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            neg_reg  <= neg_next;
            step_reg <= step_next;
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
            quo_reg  <= quo_next;
        end
    end

    assign quotient  = neg_reg ? -quo_reg : quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

FILE: sv/imu_bias_average_and_correct_core.sv
// Top level: sequencer, channel state and output register of the IMU bias average and correct block.
//
//  Channel   Handshake           Payload
//  --------  ------------------  ------------------------------------------------
//  input     in_valid/in_ready   action, accel_x/y/z, quat_x/y/z/w
//  output    out_valid/out_ready fixed_accel_x/y/z, fixed_quat_x/y/z/w
//  config    cfg_we              cfg_index (0..6), cfg_data (target per channel)
//
// After a correct request is accepted, one shared adder visits the seven channels in
// turn, then the result moves to the output register once that register is free.
// For a calibrate request, per channel, the adder adds the sample into the total, the
// one-bit-per-cycle divider forms the mean, and the adder forms the bias. A calibrate
// request with the count already full is accepted and dropped while the block stays idle.
// Reset sets count, totals and biases to zero and targets to their defaults at once.
// A result waiting on out_ready does not stop the next request from being accepted.
module imu_bias_average_and_correct_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            action,
    input  ibac_pkg::sample_t               accel_x,
    input  ibac_pkg::sample_t               accel_y,
    input  ibac_pkg::sample_t               accel_z,
    input  ibac_pkg::sample_t               quat_x,
    input  ibac_pkg::sample_t               quat_y,
    input  ibac_pkg::sample_t               quat_z,
    input  ibac_pkg::sample_t               quat_w,
    output logic                            out_valid,
    input  logic                            out_ready,
    output ibac_pkg::sample_t               fixed_accel_x,
    output ibac_pkg::sample_t               fixed_accel_y,
    output ibac_pkg::sample_t               fixed_accel_z,
    output ibac_pkg::sample_t               fixed_quat_x,
    output ibac_pkg::sample_t               fixed_quat_y,
    output ibac_pkg::sample_t               fixed_quat_z,
    output ibac_pkg::sample_t               fixed_quat_w,
    input  logic                            cfg_we,
    input  logic [ibac_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  ibac_pkg::sample_t               cfg_data
);

    localparam int CH = ibac_pkg::CHANNELS;

    // IDLE waits for a request; ACC, DIV and BIAS loop over the channels of a
    // calibrate request; CORR loops over the channels of a correct request;
    // DONE hands the finished result to the output register.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV,
        ST_BIAS,
        ST_CORR,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    ibac_pkg::chan_t     ch_reg, ch_next;
    ibac_pkg::count_t    count_reg, count_next;
    logic                out_valid_reg, out_valid_next;
    ibac_pkg::sample_t   target_reg [CH];
    ibac_pkg::sample_t   target_next [CH];
    ibac_pkg::total_t    total_reg [CH];
    ibac_pkg::total_t    total_next [CH];
    ibac_pkg::sample_t   bias_reg [CH];
    ibac_pkg::sample_t   bias_next [CH];
    ibac_pkg::sample_t   samp_reg [CH];
    ibac_pkg::sample_t   samp_next [CH];
    ibac_pkg::sample_t   res_reg [CH];
    ibac_pkg::sample_t   res_next [CH];
    ibac_pkg::sample_t   out_reg [CH];
    ibac_pkg::sample_t   out_next [CH];

    ibac_pkg::alu_op_t   alu_op;
    ibac_pkg::alu_t      alu_a;
    ibac_pkg::alu_t      alu_b;
    ibac_pkg::alu_t      alu_sum;
    ibac_pkg::sample_t   alu_sat;
    logic                div_start;
    ibac_pkg::total_t    div_quot;
    ibac_pkg::div_stat_t div_stat;
    logic                in_acc;
    logic                out_free;
    logic                last_ch;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign last_ch  = (ch_reg == ibac_pkg::chan_t'(CH - 1));

    // One adder serves every step: total plus sample while accumulating,
    // target minus mean while forming a bias, sample plus bias while correcting.
    always_comb
    begin
        unique case (state_reg)
            ST_ACC:
            begin
                alu_op = ibac_pkg::ALU_ADD;
                alu_a  = ibac_pkg::sext_total(total_reg[ch_reg]);
                alu_b  = ibac_pkg::sext_sample(samp_reg[ch_reg]);
            end
            ST_BIAS:
            begin
                alu_op = ibac_pkg::ALU_SUB;
                alu_a  = ibac_pkg::sext_sample(target_reg[ch_reg]);
                alu_b  = ibac_pkg::sext_total(div_quot);
            end
            default:
            begin
                alu_op = ibac_pkg::ALU_ADD;
                alu_a  = ibac_pkg::sext_sample(samp_reg[ch_reg]);
                alu_b  = ibac_pkg::sext_sample(bias_reg[ch_reg]);
            end
        endcase
    end

    ibac_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .sum (alu_sum),
        .sat (alu_sat)
    );

    // The new total goes straight into the divider as it is written back.
    assign div_start = (state_reg == ST_ACC);

    ibac_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (alu_sum[ibac_pkg::TOTAL_BITS-1:0]),
        .divisor  (count_reg),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        target_next    = target_reg;
        total_next     = total_reg;
        bias_next      = bias_reg;
        samp_next      = samp_reg;
        res_next       = res_reg;
        out_next       = out_reg;

        // The user must change targets only while the block is idle; the block does not enforce it.
        if (cfg_we && (cfg_index < ibac_pkg::CFG_IDX_BITS'(CH)))
        begin
            target_next[cfg_index[ibac_pkg::CHAN_BITS-1:0]] = cfg_data;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    samp_next[0] = accel_x;
                    samp_next[1] = accel_y;
                    samp_next[2] = accel_z;
                    samp_next[3] = quat_x;
                    samp_next[4] = quat_y;
                    samp_next[5] = quat_z;
                    samp_next[6] = quat_w;
                    ch_next      = '0;
                    if (action)
                    begin
                        state_next = ST_CORR;
                    end
                    else if (count_reg != ibac_pkg::COUNT_MAX)
                    begin
                        // A full count drops the calibrate request untouched.
                        count_next = count_reg + 1'b1;
                        state_next = ST_ACC;
                    end
                end
            end
            ST_ACC:
            begin
                total_next[ch_reg] = alu_sum[ibac_pkg::TOTAL_BITS-1:0];
                state_next         = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_BIAS;
                end
            end
            ST_BIAS:
            begin
                bias_next[ch_reg] = alu_sat;
                if (last_ch)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = ST_ACC;
                end
            end
            ST_CORR:
            begin
                res_next[ch_reg] = alu_sat;
                if (last_ch)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ch_next = ch_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_reg        <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            target_reg    <= ibac_pkg::TARGET_RESET;
            for (int i = 0; i < CH; i++)
            begin
                total_reg[i] <= '0;
                bias_reg[i]  <= '0;
                samp_reg[i]  <= '0;
                res_reg[i]   <= '0;
                out_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            target_reg    <= target_next;
            total_reg     <= total_next;
            bias_reg      <= bias_next;
            samp_reg      <= samp_next;
            res_reg       <= res_next;
            out_reg       <= out_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign fixed_accel_x = out_reg[0];
    assign fixed_accel_y = out_reg[1];
    assign fixed_accel_z = out_reg[2];
    assign fixed_quat_x  = out_reg[3];
    assign fixed_quat_y  = out_reg[4];
    assign fixed_quat_z  = out_reg[5];
    assign fixed_quat_w  = out_reg[6];

    // The sample count only ever steps up by one.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + 1'b1))
        else $error("sample count moved by other than one");

    // A bias is formed only right after the divider has finished.
    a_bias_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BIAS) |-> $past(div_stat.done))
        else $error("bias formed without a finished division");

    // A new result appears only from the hand-off state of a correct request.
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside the hand-off state");

    // The divider is never restarted while it is still working.
    a_div_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

endmodule

FILE: test/imu_bias_checker.sv
// Checker for the IMU bias block: tracks calibration state, predicts corrected samples, compares.
`timescale 1ns / 100ps
module imu_bias_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic                              action,
    input  ibac_pkg::sample_t                 accel_x,
    input  ibac_pkg::sample_t                 accel_y,
    input  ibac_pkg::sample_t                 accel_z,
    input  ibac_pkg::sample_t                 quat_x,
    input  ibac_pkg::sample_t                 quat_y,
    input  ibac_pkg::sample_t                 quat_z,
    input  ibac_pkg::sample_t                 quat_w,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  ibac_pkg::sample_t                 fixed_accel_x,
    input  ibac_pkg::sample_t                 fixed_accel_y,
    input  ibac_pkg::sample_t                 fixed_accel_z,
    input  ibac_pkg::sample_t                 fixed_quat_x,
    input  ibac_pkg::sample_t                 fixed_quat_y,
    input  ibac_pkg::sample_t                 fixed_quat_z,
    input  ibac_pkg::sample_t                 fixed_quat_w,
    input  logic                              cfg_we,
    input  logic [ibac_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  ibac_pkg::sample_t                 cfg_data,
    output int                                fail_count,
    output int                                expected_left,
    output int                                results_seen
);

    import ibac_pkg::*;

    localparam logic ACT_CORRECT = 1'b1;

    localparam int CH_ACCEL_Z = 2;
    localparam int CH_QUAT_W  = 6;

    localparam longint RAIL_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint RAIL_LO = -RAIL_HI - 1;

    localparam sample_t GRAVITY_TARGET = sample_t'((98 * (1 << FRACTION_BITS) + 5) / 10);
    localparam sample_t UNITY_TARGET   = sample_t'(1 << FRACTION_BITS);

    typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] frame_t;

    sample_t target_level [CHANNELS];
    sample_t bias         [CHANNELS];
    longint  running_sum  [CHANNELS];
    count_t  samples_taken;
    frame_t  corrected_due [$];

    function automatic sample_t clamp_to_rails(input longint v);
        if (v > RAIL_HI)
            return sample_t'(RAIL_HI);
        if (v < RAIL_LO)
            return sample_t'(RAIL_LO);
        return sample_t'(v);
    endfunction

    // A calibrate request folds the sample into the totals and recomputes every bias
    // from the current targets. Once the count is full the sample is dropped.
    function automatic void absorb_calibration(input frame_t s);
        longint mean;
        if (samples_taken == '1)
            return;
        samples_taken = samples_taken + 1'b1;
        for (int i = 0; i < CHANNELS; i++) begin
            running_sum[i] = running_sum[i] + longint'($signed(s[i]));
            mean           = running_sum[i] / longint'(samples_taken);
            bias[i]        = clamp_to_rails(longint'(target_level[i]) - mean);
        end
    endfunction

    function automatic frame_t corrected_sample(input frame_t s);
        frame_t f;
        for (int i = 0; i < CHANNELS; i++)
            f[i] = clamp_to_rails(longint'($signed(s[i])) + longint'(bias[i]));
        return f;
    endfunction

    function automatic string chan_label(input int ch);
        case (ch)
            0:       return "fixed_accel_x";
            1:       return "fixed_accel_y";
            2:       return "fixed_accel_z";
            3:       return "fixed_quat_x";
            4:       return "fixed_quat_y";
            5:       return "fixed_quat_z";
            default: return "fixed_quat_w";
        endcase
    endfunction

    always @(posedge clk or negedge rst_n) begin
        frame_t got;
        frame_t want;
        frame_t taken;
        if (!rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                target_level[i] = '0;
                bias[i]         = '0;
                running_sum[i]  = 0;
            end
            target_level[CH_ACCEL_Z] = GRAVITY_TARGET;
            target_level[CH_QUAT_W]  = UNITY_TARGET;
            samples_taken = '0;
            corrected_due.delete();
            fail_count    = 0;
            expected_left = 0;
            results_seen  = 0;
        end else begin
            // Results are checked before new requests are taken in, since a result can
            // never belong to the request accepted on the same edge.
            if (out_valid && out_ready) begin
                results_seen++;
                got = {fixed_quat_w, fixed_quat_z, fixed_quat_y, fixed_quat_x,
                       fixed_accel_z, fixed_accel_y, fixed_accel_x};
                if (corrected_due.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with nothing expected, expected none, got %h",
                             $time, got);
                end else begin
                    want = corrected_due.pop_front();
                    for (int i = 0; i < CHANNELS; i++) begin
                        if (got[i] !== want[i]) begin
                            fail_count++;
                            $display("%0t: %s expected %0d, got %0d", $time, chan_label(i),
                                     $signed(want[i]), $signed(got[i]));
                        end
                    end
                end
            end
            if (cfg_we && cfg_index < CHANNELS)
                target_level[cfg_index] = cfg_data;
            if (in_valid && in_ready) begin
                taken = {quat_w, quat_z, quat_y, quat_x, accel_z, accel_y, accel_x};
                if (action == ACT_CORRECT)
                    corrected_due.push_back(corrected_sample(taken));
                else
                    absorb_calibration(taken);
            end
            expected_left = corrected_due.size();
        end
    end

endmodule

FILE: test/imu_bias_average_and_correct_core_tb.sv
// Testbench top for the IMU bias average and correct block: stimulus, output pacing, verdict.
`timescale 1ns / 100ps
module imu_bias_average_and_correct_core_tb;

    import ibac_pkg::*;

    // Action codes of the request channel.
    localparam logic ACT_CALIBRATE = 1'b0;
    localparam logic ACT_CORRECT   = 1'b1;

    // Target register map; the last index is unused and must be ignored by the block.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ACCEL_X,
        REG_ACCEL_Y,
        REG_ACCEL_Z,
        REG_QUAT_X,
        REG_QUAT_Y,
        REG_QUAT_Z,
        REG_QUAT_W,
        REG_SPARE
    } cfg_reg_t;

    typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] frame_t;

    localparam int RESET_CYCLES = 8;
    // A calibrate request keeps the block busy without giving a result, so any quiet
    // point waits QUIET_CYCLES after the last result has come.
    localparam int QUIET_CYCLES = 450;
    localparam int LONG_HOLD    = 300;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 166;
    localparam int HOLD_PHASE   = 3;
    localparam int PAUSE_PHASE  = 5;
    localparam int LIMIT        = 4_000_000;

    logic    clk       = 1'b0;
    logic    rst_n     = 1'b0;
    logic    in_valid  = 1'b0;
    logic    in_ready;
    logic    action    = ACT_CALIBRATE;
    sample_t accel_x   = '0;
    sample_t accel_y   = '0;
    sample_t accel_z   = '0;
    sample_t quat_x    = '0;
    sample_t quat_y    = '0;
    sample_t quat_z    = '0;
    sample_t quat_w    = '0;
    logic    out_valid;
    logic    out_ready = 1'b0;
    sample_t fixed_accel_x;
    sample_t fixed_accel_y;
    sample_t fixed_accel_z;
    sample_t fixed_quat_x;
    sample_t fixed_quat_y;
    sample_t fixed_quat_z;
    sample_t fixed_quat_w;
    logic                    cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = REG_ACCEL_X;
    sample_t                 cfg_data  = '0;

    int mismatches;
    int expected_left;
    int results_checked;

    // Stimulus bookkeeping and the flags that steer the output pacing process.
    int   calibrates_sent = 0;
    int   corrects_sent   = 0;
    int   target_sets     = 0;
    int   cycle_count     = 0;
    logic steady          = 1'b0;
    logic hold_request    = 1'b0;
    logic hold_served     = 1'b0;

    imu_bias_average_and_correct_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .accel_x       (accel_x),
        .accel_y       (accel_y),
        .accel_z       (accel_z),
        .quat_x        (quat_x),
        .quat_y        (quat_y),
        .quat_z        (quat_z),
        .quat_w        (quat_w),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .fixed_accel_x (fixed_accel_x),
        .fixed_accel_y (fixed_accel_y),
        .fixed_accel_z (fixed_accel_z),
        .fixed_quat_x  (fixed_quat_x),
        .fixed_quat_y  (fixed_quat_y),
        .fixed_quat_z  (fixed_quat_z),
        .fixed_quat_w  (fixed_quat_w),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    imu_bias_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .accel_x       (accel_x),
        .accel_y       (accel_y),
        .accel_z       (accel_z),
        .quat_x        (quat_x),
        .quat_y        (quat_y),
        .quat_z        (quat_z),
        .quat_w        (quat_w),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .fixed_accel_x (fixed_accel_x),
        .fixed_accel_y (fixed_accel_y),
        .fixed_accel_z (fixed_accel_z),
        .fixed_quat_x  (fixed_quat_x),
        .fixed_quat_y  (fixed_quat_y),
        .fixed_quat_z  (fixed_quat_z),
        .fixed_quat_w  (fixed_quat_w),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (mismatches),
        .expected_left (expected_left),
        .results_seen  (results_checked)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT)
        begin
            $display("imu_bias_average_and_correct_core_tb: done, errors");
            $finish;
        end
    end

    // Offers one request and returns on the edge that accepts it. Valid is only ever
    // lowered in a step where it is not also raised, so the item stays stable until taken.
    task automatic offer(input logic act, input frame_t item);
        if (!steady && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        accel_x  <= item[REG_ACCEL_X];
        accel_y  <= item[REG_ACCEL_Y];
        accel_z  <= item[REG_ACCEL_Z];
        quat_x   <= item[REG_QUAT_X];
        quat_y   <= item[REG_QUAT_Y];
        quat_z   <= item[REG_QUAT_Z];
        quat_w   <= item[REG_QUAT_W];
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (act == ACT_CORRECT)
            corrects_sent++;
        else
            calibrates_sent++;
    endtask

    // Stops offering, waits for every corrected result still owed, then lets any
    // calibrate request that is still in the divider run out.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_left != 0) @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // Writes all seven targets, then a junk value to the unused index. Only called
    // while the block is idle.
    task automatic load_targets(input frame_t levels);
        for (int i = 0; i < CHANNELS; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= cfg_reg_t'(i);
            cfg_data  <= levels[i];
            @(posedge clk);
        end
        cfg_we    <= 1'b1;
        cfg_index <= REG_SPARE;
        cfg_data  <= $urandom;
        @(posedge clk);
        cfg_we <= 1'b0;
        target_sets++;
    endtask

    function automatic frame_t alternate(input sample_t even_ch, input sample_t odd_ch);
        frame_t f;
        for (int i = 0; i < CHANNELS; i++)
            f[i] = (i % 2 == 0) ? even_ch : odd_ch;
        return f;
    endfunction

    // Half the samples sit near the channel's center with noise of random magnitude;
    // the rest are raw random words, rail values, zero, minus one, one and small signed values.
    function automatic sample_t draw_sample(input sample_t center);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return center + sample_t'($signed($urandom) >>> $urandom_range(8, 31));
        if (pick < 70)
            return sample_t'($urandom);
        if (pick < 85)
        begin
            case ($urandom_range(0, 4))
                0:       return SAMPLE_MAX;
                1:       return SAMPLE_MIN;
                2:       return '0;
                3:       return '1;
                default: return sample_t'(1);
            endcase
        end
        return sample_t'($signed($urandom) >>> 12);
    endfunction

    // Output pacing. Random stalls between ready stretches; one long hold while the sender
    // keeps offering, so the block fills and stops taking requests; no stalls at all once
    // the final steady phase has begun.
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (hold_request && !hold_served)
            begin
                hold_served = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!steady && $urandom_range(0, 9) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end
    end

    initial
    begin
        frame_t levels;
        frame_t center;
        frame_t item;
        int     lead;
        logic   act;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset targets. With no calibration yet every bias is
        // zero, so corrected samples must come back unchanged, rails included.
        offer(ACT_CORRECT, {CHANNELS{SAMPLE_MAX}});
        offer(ACT_CORRECT, {CHANNELS{SAMPLE_MIN}});
        offer(ACT_CORRECT, '0);
        offer(ACT_CORRECT, '1);
        offer(ACT_CORRECT, alternate(sample_t'(32'h5555_5555), sample_t'(32'hAAAA_AAAA)));

        // Three calibrations leave totals of -2 over a count of 3: the mean truncates
        // toward zero, to 0 rather than -1, so each bias equals its target.
        offer(ACT_CALIBRATE, {CHANNELS{SAMPLE_MAX}});
        offer(ACT_CALIBRATE, {CHANNELS{SAMPLE_MIN}});
        offer(ACT_CALIBRATE, '1);
        offer(ACT_CORRECT, '0);
        offer(ACT_CORRECT, {CHANNELS{SAMPLE_MIN}});

        // Targets at opposite rails, then calibration against the other rail, drive
        // the biases into saturation in both directions.
        settle();
        load_targets(alternate(SAMPLE_MAX, SAMPLE_MIN));
        offer(ACT_CALIBRATE, alternate(SAMPLE_MIN, SAMPLE_MAX));
        offer(ACT_CORRECT, {CHANNELS{SAMPLE_MAX}});
        offer(ACT_CORRECT, {CHANNELS{SAMPLE_MIN}});
        offer(ACT_CORRECT, alternate(SAMPLE_MAX, SAMPLE_MIN));
        offer(ACT_CALIBRATE, alternate(SAMPLE_MAX, SAMPLE_MIN));
        offer(ACT_CORRECT, alternate(sample_t'(1), '1));
        offer(ACT_CORRECT, alternate(SAMPLE_MIN, SAMPLE_MAX));

        // Random phases. Each one loads a new target set while idle, runs a stretch of
        // mostly calibration samples as a stationary sensor would, then mostly corrections
        // with a few stray calibrations mixed in.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            case (ph)
                0:
                begin
                    levels = '0;
                    levels[REG_ACCEL_Z] = sample_t'(GRAVITY_FIX);
                    levels[REG_QUAT_W]  = sample_t'(ONE_FIX);
                end
                1:       levels = {CHANNELS{SAMPLE_MIN}};
                2:       levels = {CHANNELS{SAMPLE_MAX}};
                default:
                begin
                    for (int i = 0; i < CHANNELS; i++)
                        levels[i] = draw_sample('0);
                end
            endcase
            load_targets(levels);

            // The sensor's true offset from target differs per phase and per channel.
            for (int i = 0; i < CHANNELS; i++)
                center[i] = levels[i] + sample_t'($signed($urandom) >>> $urandom_range(6, 31));

            steady = (ph == PHASES - 1);
            lead   = $urandom_range(15, 60);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (ph == HOLD_PHASE && k == lead)
                    hold_request = 1'b1;
                if (ph == PAUSE_PHASE && k == PHASE_ITEMS / 2)
                    settle();
                if (k < lead)
                    act = ($urandom_range(0, 9) == 0) ? ACT_CORRECT : ACT_CALIBRATE;
                else
                    act = ($urandom_range(0, 6) == 0) ? ACT_CALIBRATE : ACT_CORRECT;
                for (int i = 0; i < CHANNELS; i++)
                    item[i] = draw_sample(center[i]);
                offer(act, item);
            end
        end

        settle();
        $display("covered %0d calibrate and %0d correct requests over %0d target sets,",
                 calibrates_sent, corrects_sent, target_sets);
        $display("%0d corrected results checked, incl. rail saturation and a long output stall",
                 results_checked);
        if (mismatches == 0 && expected_left == 0)
            $display("imu_bias_average_and_correct_core_tb: done, clean");
        else
            $display("imu_bias_average_and_correct_core_tb: done, errors");
        $finish;
    end

endmodule

FILE: filelist.f
sv/ibac_pkg.sv
sv/ibac_alu.sv
sv/ibac_divider.sv
sv/imu_bias_average_and_correct_core.sv
test/imu_bias_checker.sv
test/imu_bias_average_and_correct_core_tb.sv
